FILE: rtl/sm83_pkg.sv
package sm83_pkg;

    // One bus request as it leaves the core
    typedef struct packed {
        logic        bus_write;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic        instr_done;
        logic [4:0]  instr_cycles;
        logic        fault;
        logic [7:0]  acc_value;
        logic [3:0]  flag_bits;
        logic        end_of_run;
    } t_result;

    // Input word kinds
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // Implemented opcodes
    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_DEC_B   = 8'h05;
    localparam logic [7:0] OP_LD_B_N  = 8'h06;
    localparam logic [7:0] OP_DEC_C   = 8'h0D;
    localparam logic [7:0] OP_LD_C_N  = 8'h0E;
    localparam logic [7:0] OP_JR_NZ   = 8'h20;
    localparam logic [7:0] OP_LD_HL   = 8'h21;
    localparam logic [7:0] OP_LDD_HL  = 8'h32;
    localparam logic [7:0] OP_LD_A_N  = 8'h3E;
    localparam logic [7:0] OP_XOR_A   = 8'hAF;
    localparam logic [7:0] OP_JP      = 8'hC3;
    localparam logic [7:0] OP_LDH_ST  = 8'hE0;
    localparam logic [7:0] OP_LDH_LD  = 8'hF0;
    localparam logic [7:0] OP_DI      = 8'hF3;
    localparam logic [7:0] OP_CP_N    = 8'hFE;

    // Flag bit positions in the 4-bit flag word
    localparam int FL_Z = 3;
    localparam int FL_N = 2;
    localparam int FL_H = 1;
    localparam int FL_C = 0;

    // High-page base for LDH
    localparam logic [7:0] HIGH_PAGE = 8'hFF;

    // Register values after reset
    localparam logic [7:0]  RST_ACC   = 8'h01;
    localparam logic [3:0]  RST_FLAGS = 4'hB;
    localparam logic [7:0]  RST_B     = 8'h00;
    localparam logic [7:0]  RST_C     = 8'h13;
    localparam logic [7:0]  RST_H     = 8'h01;
    localparam logic [7:0]  RST_L     = 8'h4D;
    localparam logic [15:0] RST_PC    = 16'h0100;

    // Result queue geometry
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = 3;
    // room for the two results of a store instruction
    localparam logic [OUTQ_CW-1:0] OUTQ_ROOM = OUTQ_CW'(OUTQ_DEPTH - 2);

endpackage

FILE: rtl/sm83_exec.sv
module sm83_exec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_func,
    input  logic [7:0]         i_read_data,
    output sm83_pkg::t_result  o_res0,
    output sm83_pkg::t_result  o_res1,
    output logic [1:0]         o_res_count
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPCODE,
        PH_IMM8,
        PH_IMM16_LO,
        PH_IMM16_HI,
        PH_LDH_DATA
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_acc, n_acc;
    logic [3:0]  r_flags, n_flags;
    logic [7:0]  r_b, n_b;
    logic [7:0]  r_c, n_c;
    logic [7:0]  r_h, n_h;
    logic [7:0]  r_l, n_l;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_op, n_op;
    logic [7:0]  r_imm_lo, n_imm_lo;
    logic        r_halted, n_halted;
    logic [15:0] r_fault_addr, n_fault_addr;

    sm83_pkg::t_result res0, res1;
    logic [1:0]        res_count;
    logic [15:0]       pc_inc;
    logic [15:0]       hl;
    logic [7:0]        dec_val;
    logic [7:0]        d;

    function automatic sm83_pkg::t_result mk_res(
        input logic        wr,
        input logic [15:0] addr,
        input logic [7:0]  data,
        input logic        done,
        input logic [4:0]  cyc,
        input logic        flt
    );
        sm83_pkg::t_result r;
        r              = '0;
        r.bus_write    = wr;
        r.bus_address  = addr;
        r.write_data   = data;
        r.instr_done   = done;
        r.instr_cycles = cyc;
        r.fault        = flt;
        return r;
    endfunction

    assign d      = i_read_data;
    assign pc_inc = r_pc + 16'd1;
    assign hl     = {r_h, r_l};

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_flags      = r_flags;
        n_b          = r_b;
        n_c          = r_c;
        n_h          = r_h;
        n_l          = r_l;
        n_pc         = r_pc;
        n_op         = r_op;
        n_imm_lo     = r_imm_lo;
        n_halted     = r_halted;
        n_fault_addr = r_fault_addr;
        res0         = '0;
        res1         = '0;
        res_count    = 2'd0;
        dec_val      = 8'h00;

        if (r_halted) begin
            res0      = mk_res(1'b0, r_fault_addr, 8'h00, 1'b0, 5'd0, 1'b1);
            res_count = 2'd1;
        end else if (i_func == sm83_pkg::FUNC_START) begin
            n_phase   = PH_OPCODE;
            res0      = mk_res(1'b0, r_pc, 8'h00, 1'b0, 5'd0, 1'b0);
            res_count = 2'd1;
        end else begin
            case (r_phase)
                PH_OPCODE: begin
                    n_op      = d;
                    n_pc      = pc_inc;
                    n_phase   = PH_OPCODE;
                    res_count = 2'd1;
                    case (d)
                        sm83_pkg::OP_NOP, sm83_pkg::OP_DI: begin
                            res0 = mk_res(1'b0, pc_inc, 8'h00, 1'b1, 5'd4, 1'b0);
                        end
                        sm83_pkg::OP_DEC_B, sm83_pkg::OP_DEC_C: begin
                            dec_val = ((d == sm83_pkg::OP_DEC_B) ? r_b : r_c) - 8'd1;
                            if (d == sm83_pkg::OP_DEC_B) begin
                                n_b = dec_val;
                            end else begin
                                n_c = dec_val;
                            end
                            n_flags[sm83_pkg::FL_Z] = (dec_val == 8'h00);
                            n_flags[sm83_pkg::FL_N] = 1'b1;
                            n_flags[sm83_pkg::FL_H] = (dec_val[3:0] == 4'hF);
                            res0 = mk_res(1'b0, pc_inc, 8'h00, 1'b1, 5'd4, 1'b0);
                        end
                        sm83_pkg::OP_XOR_A: begin
                            n_acc   = 8'h00;
                            n_flags = 4'b1000;
                            res0 = mk_res(1'b0, pc_inc, 8'h00, 1'b1, 5'd4, 1'b0);
                        end
                        sm83_pkg::OP_LD_B_N, sm83_pkg::OP_LD_C_N, sm83_pkg::OP_LD_A_N,
                        sm83_pkg::OP_LDH_ST, sm83_pkg::OP_LDH_LD, sm83_pkg::OP_CP_N: begin
                            n_phase = PH_IMM8;
                            res0 = mk_res(1'b0, pc_inc, 8'h00, 1'b0, 5'd0, 1'b0);
                        end
                        sm83_pkg::OP_JR_NZ: begin
                            if (r_flags[sm83_pkg::FL_Z]) begin
                                // not taken: offset byte skipped unread
                                n_pc = r_pc + 16'd2;
                                res0 = mk_res(1'b0, r_pc + 16'd2, 8'h00, 1'b1, 5'd8, 1'b0);
                            end else begin
                                n_phase = PH_IMM8;
                                res0 = mk_res(1'b0, pc_inc, 8'h00, 1'b0, 5'd0, 1'b0);
                            end
                        end
                        sm83_pkg::OP_LD_HL, sm83_pkg::OP_JP: begin
                            n_phase = PH_IMM16_LO;
                            res0 = mk_res(1'b0, pc_inc, 8'h00, 1'b0, 5'd0, 1'b0);
                        end
                        sm83_pkg::OP_LDD_HL: begin
                            {n_h, n_l} = hl - 16'd1;
                            res0 = mk_res(1'b1, hl, r_acc, 1'b0, 5'd0, 1'b0);
                            res1 = mk_res(1'b0, pc_inc, 8'h00, 1'b1, 5'd8, 1'b0);
                            res_count = 2'd2;
                        end
                        default: begin
                            // unimplemented opcode: halt until reset
                            n_halted     = 1'b1;
                            n_phase      = PH_IDLE;
                            n_fault_addr = r_pc;
                            res0 = mk_res(1'b0, r_pc, 8'h00, 1'b0, 5'd0, 1'b1);
                        end
                    endcase
                end
                PH_IMM8: begin
                    n_pc      = pc_inc;
                    n_phase   = PH_OPCODE;
                    res_count = 2'd1;
                    case (r_op)
                        sm83_pkg::OP_LD_B_N: begin
                            n_b  = d;
                            res0 = mk_res(1'b0, pc_inc, 8'h00, 1'b1, 5'd8, 1'b0);
                        end
                        sm83_pkg::OP_LD_C_N: begin
                            n_c  = d;
                            res0 = mk_res(1'b0, pc_inc, 8'h00, 1'b1, 5'd8, 1'b0);
                        end
                        sm83_pkg::OP_LD_A_N: begin
                            n_acc = d;
                            res0  = mk_res(1'b0, pc_inc, 8'h00, 1'b1, 5'd8, 1'b0);
                        end
                        sm83_pkg::OP_JR_NZ: begin
                            n_pc = pc_inc + {{8{d[7]}}, d};
                            res0 = mk_res(1'b0, pc_inc + {{8{d[7]}}, d}, 8'h00,
                                          1'b1, 5'd12, 1'b0);
                        end
                        sm83_pkg::OP_LDH_ST: begin
                            res0 = mk_res(1'b1, {sm83_pkg::HIGH_PAGE, d}, r_acc,
                                          1'b0, 5'd0, 1'b0);
                            res1 = mk_res(1'b0, pc_inc, 8'h00, 1'b1, 5'd12, 1'b0);
                            res_count = 2'd2;
                        end
                        sm83_pkg::OP_LDH_LD: begin
                            n_phase = PH_LDH_DATA;
                            res0 = mk_res(1'b0, {sm83_pkg::HIGH_PAGE, d}, 8'h00,
                                          1'b0, 5'd0, 1'b0);
                        end
                        default: begin
                            // CP n
                            n_flags[sm83_pkg::FL_Z] = (r_acc == d);
                            n_flags[sm83_pkg::FL_N] = 1'b1;
                            n_flags[sm83_pkg::FL_H] = (r_acc[3:0] < d[3:0]);
                            n_flags[sm83_pkg::FL_C] = (r_acc < d);
                            res0 = mk_res(1'b0, pc_inc, 8'h00, 1'b1, 5'd8, 1'b0);
                        end
                    endcase
                end
                PH_IMM16_LO: begin
                    n_imm_lo  = d;
                    n_pc      = pc_inc;
                    n_phase   = PH_IMM16_HI;
                    res0      = mk_res(1'b0, pc_inc, 8'h00, 1'b0, 5'd0, 1'b0);
                    res_count = 2'd1;
                end
                PH_IMM16_HI: begin
                    n_phase   = PH_OPCODE;
                    res_count = 2'd1;
                    if (r_op == sm83_pkg::OP_LD_HL) begin
                        n_h  = d;
                        n_l  = r_imm_lo;
                        n_pc = pc_inc;
                        res0 = mk_res(1'b0, pc_inc, 8'h00, 1'b1, 5'd12, 1'b0);
                    end else begin
                        n_pc = {d, r_imm_lo};
                        res0 = mk_res(1'b0, {d, r_imm_lo}, 8'h00, 1'b1, 5'd16, 1'b0);
                    end
                end
                PH_LDH_DATA: begin
                    n_acc     = d;
                    n_phase   = PH_OPCODE;
                    res0      = mk_res(1'b0, r_pc, 8'h00, 1'b1, 5'd12, 1'b0);
                    res_count = 2'd1;
                end
                default: begin
                    // data before any start: dropped
                    res_count = 2'd0;
                end
            endcase
        end

        // both words of an item report the state after the whole step
        res0.acc_value  = n_acc;
        res0.flag_bits  = n_flags;
        res0.end_of_run = (res_count == 2'd1);
        res1.acc_value  = n_acc;
        res1.flag_bits  = n_flags;
        res1.end_of_run = 1'b1;
    end

    assign o_res0      = res0;
    assign o_res1      = res1;
    assign o_res_count = i_fire ? res_count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_acc        <= sm83_pkg::RST_ACC;
            r_flags      <= sm83_pkg::RST_FLAGS;
            r_b          <= sm83_pkg::RST_B;
            r_c          <= sm83_pkg::RST_C;
            r_h          <= sm83_pkg::RST_H;
            r_l          <= sm83_pkg::RST_L;
            r_pc         <= sm83_pkg::RST_PC;
            r_op         <= 8'h00;
            r_imm_lo     <= 8'h00;
            r_halted     <= 1'b0;
            r_fault_addr <= 16'h0000;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_flags      <= n_flags;
            r_b          <= n_b;
            r_c          <= n_c;
            r_h          <= n_h;
            r_l          <= n_l;
            r_pc         <= n_pc;
            r_op         <= n_op;
            r_imm_lo     <= n_imm_lo;
            r_halted     <= n_halted;
            r_fault_addr <= n_fault_addr;
        end
    end

endmodule

FILE: rtl/sm83_outq.sv
module sm83_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_count,
    input  sm83_pkg::t_result  i_push0,
    input  sm83_pkg::t_result  i_push1,
    input  logic               i_pop,
    output sm83_pkg::t_result  o_head,
    output logic               o_valid,
    output logic               o_room
);

    sm83_pkg::t_result              r_mem [sm83_pkg::OUTQ_DEPTH];
    logic [sm83_pkg::OUTQ_AW-1:0]   r_wp, n_wp;
    logic [sm83_pkg::OUTQ_AW-1:0]   r_rp, n_rp;
    logic [sm83_pkg::OUTQ_CW-1:0]   r_count, n_count;
    logic [sm83_pkg::OUTQ_AW-1:0]   wp_next;

    assign wp_next = r_wp + 1'b1;
    assign n_wp    = r_wp + i_push_count[sm83_pkg::OUTQ_AW-1:0];
    assign n_rp    = i_pop ? (r_rp + 1'b1) : r_rp;
    assign n_count = r_count + {{(sm83_pkg::OUTQ_CW-2){1'b0}}, i_push_count}
                     - {{(sm83_pkg::OUTQ_CW-1){1'b0}}, i_pop};

    assign o_head  = r_mem[r_rp];
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= sm83_pkg::OUTQ_ROOM);

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wp] <= i_push0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wp_next] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/sm83_cpu_subset_core.sv
// Channel   Direction  Handshake               Payload
// in        to core    i_in_valid/o_in_stall   i_func, i_read_data
// out       from core  o_out_valid/i_out_stall bus request, done/cycles, fault, A, flags
//
// One input word per cycle while o_in_stall is low: a word waits in the input register,
// is executed by single-pass logic against the register file, and its 0, 1 or 2 bus
// words drop into a 4-entry result queue; each word passes the input register and then
// the queue before it can leave, and a stream of stores drains at one output word per
// cycle while i_out_stall is low. Synchronous active-low reset; comes up idle.
// Once fewer than two queue slots are free the input register holds (o_in_stall).
module sm83_cpu_subset_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_read_data,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_bus_write,
    output logic [15:0] o_bus_address,
    output logic [7:0]  o_write_data,
    output logic        o_instr_done,
    output logic [4:0]  o_instr_cycles,
    output logic        o_fault,
    output logic [7:0]  o_acc_value,
    output logic [3:0]  o_flag_bits,
    output logic        o_end_of_run
);

    // input register
    logic       r_in_valid, n_in_valid;
    logic       r_in_func;
    logic [7:0] r_in_data;

    logic              fire;
    logic              in_take;
    logic              q_room;
    logic              q_valid;
    logic              q_pop;
    logic [1:0]        res_count;
    sm83_pkg::t_result res0, res1, head;

    // execute when a word is waiting and the queue can hold a two-word result
    assign fire       = r_in_valid && q_room;
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;
    assign n_in_valid = in_take ? 1'b1 : (fire ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func <= i_func;
            r_in_data <= i_read_data;
        end
    end

    sm83_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_func      (r_in_func),
        .i_read_data (r_in_data),
        .o_res0      (res0),
        .o_res1      (res1),
        .o_res_count (res_count)
    );

    assign q_pop = q_valid && !i_out_stall;

    sm83_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (res_count),
        .i_push0      (res0),
        .i_push1      (res1),
        .i_pop        (q_pop),
        .o_head       (head),
        .o_valid      (q_valid),
        .o_room       (q_room)
    );

    assign o_out_valid    = q_valid;
    assign o_bus_write    = head.bus_write;
    assign o_bus_address  = head.bus_address;
    assign o_write_data   = head.write_data;
    assign o_instr_done   = head.instr_done;
    assign o_instr_cycles = head.instr_cycles;
    assign o_fault        = head.fault;
    assign o_acc_value    = head.acc_value;
    assign o_flag_bits    = head.flag_bits;
    assign o_end_of_run   = head.end_of_run;

`ifndef SYNTHESIS
    // a fault word is a plain read with no completion attached
    a_fault_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fault) |-> (!o_instr_done && !o_bus_write))
        else $error("fault word carries a write or a completion");

    // a completion is always a read that charges a nonzero cost
    a_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_instr_done) |-> (!o_bus_write && o_instr_cycles != 5'd0))
        else $error("completion word malformed");

    // a held input word keeps its payload until it executes
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in_data)
                                   && $stable(r_in_func)))
        else $error("input register lost a waiting word");

    // write words are never the last word of an item
    a_write_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bus_write) |-> !o_end_of_run)
        else $error("write word marked as last");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

// Testbench for sm83_cpu_subset_core.
// Input words are start commands or read data returned by memory. Output words
// are bus requests. A cycle-level predictor of the CPU subset runs on each
// accepted input word and queues the bus words it expects. A monitor pops one
// expected word per accepted output word and compares field by field.
module tb;

    localparam int         LIMIT_CYCLES = 400000;
    localparam int         RAND_WORDS   = 1370;
    localparam int         CALM_WORDS   = 150;   // no idling in the last stretch
    localparam logic [7:0] BAD_OPCODE   = 8'hD3; // not in the subset, halts the core

    // all opcodes the core runs; random programs draw from this set only,
    // since a fault would hold the core until the next reset
    localparam logic [7:0] GOOD_OPS [15] = '{
        sm83_pkg::OP_NOP, sm83_pkg::OP_DEC_B, sm83_pkg::OP_LD_B_N, sm83_pkg::OP_DEC_C,
        sm83_pkg::OP_LD_C_N, sm83_pkg::OP_JR_NZ, sm83_pkg::OP_LD_HL,
        sm83_pkg::OP_LDD_HL, sm83_pkg::OP_LD_A_N, sm83_pkg::OP_XOR_A, sm83_pkg::OP_JP,
        sm83_pkg::OP_LDH_ST, sm83_pkg::OP_LDH_LD, sm83_pkg::OP_DI, sm83_pkg::OP_CP_N
    };

    // what the core waits for next
    typedef enum logic [2:0] {
        ST_IDLE, ST_OPCODE, ST_IMM8, ST_IMM_LO, ST_IMM_HI, ST_LDH_DATA
    } t_phase;

    // one stimulus row; known rows carry a hand-typed bus word
    typedef struct packed {
        logic              func;
        logic [7:0]        data;
        logic              known;
        sm83_pkg::t_result want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_func;
    logic [7:0]  i_read_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_bus_write;
    logic [15:0] o_bus_address;
    logic [7:0]  o_write_data;
    logic        o_instr_done;
    logic [4:0]  o_instr_cycles;
    logic        o_fault;
    logic [7:0]  o_acc_value;
    logic [3:0]  o_flag_bits;
    logic        o_end_of_run;

    sm83_cpu_subset_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_read_data    (i_read_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bus_write    (o_bus_write),
        .o_bus_address  (o_bus_address),
        .o_write_data   (o_write_data),
        .o_instr_done   (o_instr_done),
        .o_instr_cycles (o_instr_cycles),
        .o_fault        (o_fault),
        .o_acc_value    (o_acc_value),
        .o_flag_bits    (o_flag_bits),
        .o_end_of_run   (o_end_of_run)
    );

    // ---------------------------------------------------------------
    // Clock, cycle counter
    // ---------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    int cycle_cnt = 0;
    int err_cnt   = 0;
    bit quiet     = 1'b0;   // set for the closing stretch: no gaps, no stalls

    // ---------------------------------------------------------------
    // CPU predictor: architectural state plus the decode phase
    // ---------------------------------------------------------------
    logic [7:0]  cpu_a, cpu_b, cpu_c, cpu_h, cpu_l;
    logic [3:0]  cpu_f;
    logic [15:0] cpu_pc, cpu_fault_pc;
    logic [7:0]  cpu_op, cpu_lo;
    logic        cpu_halt;
    t_phase      cpu_ph;

    sm83_pkg::t_result step_res [2];   // bus words caused by the current input word
    int                step_n;
    sm83_pkg::t_result bus_q [$];      // bus words expected from the core, oldest first

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d bus words still expected", $time, bus_q.size());
            $display("sm83_cpu_subset_core test failed");
            $finish;
        end
    end

    function automatic void cpu_reset();
        cpu_a        = sm83_pkg::RST_ACC;
        cpu_f        = sm83_pkg::RST_FLAGS;
        cpu_b        = sm83_pkg::RST_B;
        cpu_c        = sm83_pkg::RST_C;
        cpu_h        = sm83_pkg::RST_H;
        cpu_l        = sm83_pkg::RST_L;
        cpu_pc       = sm83_pkg::RST_PC;
        cpu_fault_pc = '0;
        cpu_op       = '0;
        cpu_lo       = '0;
        cpu_halt     = 1'b0;
        cpu_ph       = ST_IDLE;
    endfunction

    // A and flags are reported as they stand when the request is made
    function automatic void add_req(logic wr, logic [15:0] addr, logic [7:0] wd,
                                    logic done, logic [4:0] cyc, logic flt);
        sm83_pkg::t_result r;
        r.bus_write    = wr;
        r.bus_address  = addr;
        r.write_data   = wd;
        r.instr_done   = done;
        r.instr_cycles = cyc;
        r.fault        = flt;
        r.acc_value    = cpu_a;
        r.flag_bits    = cpu_f;
        r.end_of_run   = 1'b0;
        step_res[step_n] = r;
        step_n++;
    endfunction

    // instruction retired: fetch the next opcode and report its cost
    function automatic void fetch_next(logic [4:0] cyc);
        cpu_ph = ST_OPCODE;
        add_req(1'b0, cpu_pc, 8'h00, 1'b1, cyc, 1'b0);
    endfunction

    function automatic void need_operand(t_phase nxt);
        cpu_ph = nxt;
        add_req(1'b0, cpu_pc, 8'h00, 1'b0, 5'd0, 1'b0);
    endfunction

    // DEC keeps C, sets N, Z on zero, H on borrow out of the low nibble
    function automatic logic [7:0] dec8(logic [7:0] v);
        logic [7:0] r;
        r = v - 8'd1;
        cpu_f[sm83_pkg::FL_Z] = (r == 8'h00);
        cpu_f[sm83_pkg::FL_N] = 1'b1;
        cpu_f[sm83_pkg::FL_H] = (r[3:0] == 4'hF);
        return r;
    endfunction

    function automatic void exec_opcode(logic [7:0] op);
        logic [15:0] hl;
        cpu_fault_pc = cpu_pc;
        cpu_op       = op;
        cpu_pc       = cpu_pc + 16'd1;
        case (op)
            sm83_pkg::OP_NOP, sm83_pkg::OP_DI: fetch_next(5'd4);
            sm83_pkg::OP_DEC_B: begin
                cpu_b = dec8(cpu_b);
                fetch_next(5'd4);
            end
            sm83_pkg::OP_DEC_C: begin
                cpu_c = dec8(cpu_c);
                fetch_next(5'd4);
            end
            sm83_pkg::OP_XOR_A: begin
                cpu_a                 = 8'h00;
                cpu_f                 = '0;
                cpu_f[sm83_pkg::FL_Z] = 1'b1;
                fetch_next(5'd4);
            end
            sm83_pkg::OP_LD_B_N, sm83_pkg::OP_LD_C_N, sm83_pkg::OP_LD_A_N,
            sm83_pkg::OP_LDH_ST, sm83_pkg::OP_LDH_LD, sm83_pkg::OP_CP_N:
                need_operand(ST_IMM8);
            sm83_pkg::OP_JR_NZ: begin
                // branch not taken: offset byte skipped unread
                if (cpu_f[sm83_pkg::FL_Z]) begin
                    cpu_pc = cpu_pc + 16'd1;
                    fetch_next(5'd8);
                end else begin
                    need_operand(ST_IMM8);
                end
            end
            sm83_pkg::OP_LD_HL, sm83_pkg::OP_JP: need_operand(ST_IMM_LO);
            sm83_pkg::OP_LDD_HL: begin
                hl = {cpu_h, cpu_l};
                add_req(1'b1, hl, cpu_a, 1'b0, 5'd0, 1'b0);
                {cpu_h, cpu_l} = hl - 16'd1;
                fetch_next(5'd8);
            end
            default: begin
                cpu_halt = 1'b1;
                cpu_ph   = ST_IDLE;
                add_req(1'b0, cpu_fault_pc, 8'h00, 1'b0, 5'd0, 1'b1);
            end
        endcase
    endfunction

    function automatic void exec_imm8(logic [7:0] d);
        cpu_pc = cpu_pc + 16'd1;
        case (cpu_op)
            sm83_pkg::OP_LD_B_N: begin
                cpu_b = d;
                fetch_next(5'd8);
            end
            sm83_pkg::OP_LD_C_N: begin
                cpu_c = d;
                fetch_next(5'd8);
            end
            sm83_pkg::OP_LD_A_N: begin
                cpu_a = d;
                fetch_next(5'd8);
            end
            sm83_pkg::OP_JR_NZ: begin
                cpu_pc = cpu_pc + {{8{d[7]}}, d};
                fetch_next(5'd12);
            end
            sm83_pkg::OP_LDH_ST: begin
                add_req(1'b1, {sm83_pkg::HIGH_PAGE, d}, cpu_a, 1'b0, 5'd0, 1'b0);
                fetch_next(5'd12);
            end
            sm83_pkg::OP_LDH_LD: begin
                cpu_ph = ST_LDH_DATA;
                add_req(1'b0, {sm83_pkg::HIGH_PAGE, d}, 8'h00, 1'b0, 5'd0, 1'b0);
            end
            default: begin  // CP n
                cpu_f                 = '0;
                cpu_f[sm83_pkg::FL_N] = 1'b1;
                cpu_f[sm83_pkg::FL_Z] = (cpu_a == d);
                cpu_f[sm83_pkg::FL_H] = (cpu_a[3:0] < d[3:0]);
                cpu_f[sm83_pkg::FL_C] = (cpu_a < d);
                fetch_next(5'd8);
            end
        endcase
    endfunction

    // one accepted input word -> step_res[0 .. step_n-1]
    function automatic void exec_word(logic f, logic [7:0] d);
        step_n = 0;
        if (cpu_halt) begin
            add_req(1'b0, cpu_fault_pc, 8'h00, 1'b0, 5'd0, 1'b1);
        end else if (f == sm83_pkg::FUNC_START) begin
            // also abandons an instruction in flight; consumed operands stay consumed
            cpu_ph = ST_OPCODE;
            add_req(1'b0, cpu_pc, 8'h00, 1'b0, 5'd0, 1'b0);
        end else begin
            case (cpu_ph)
                ST_OPCODE: exec_opcode(d);
                ST_IMM8:   exec_imm8(d);
                ST_IMM_LO: begin
                    cpu_lo = d;
                    cpu_pc = cpu_pc + 16'd1;
                    need_operand(ST_IMM_HI);
                end
                ST_IMM_HI: begin
                    cpu_pc = cpu_pc + 16'd1;
                    if (cpu_op == sm83_pkg::OP_LD_HL) begin
                        cpu_h = d;
                        cpu_l = cpu_lo;
                        fetch_next(5'd12);
                    end else begin
                        cpu_pc = {d, cpu_lo};
                        fetch_next(5'd16);
                    end
                end
                ST_LDH_DATA: begin
                    cpu_a = d;
                    fetch_next(5'd12);
                end
                default: ;  // read data before any start: ignored
            endcase
        end
    endfunction

    // ---------------------------------------------------------------
    // Output side: random stall bursts, word checker
    // ---------------------------------------------------------------
    int stall_left = 0;

    // stalls come in random bursts; while cycle_cnt bit 9 is set the output is stall free
    always @(posedge i_clk) begin
        if (quiet || cycle_cnt[9]) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 11);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        sm83_pkg::t_result want_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bus_q.size() == 0) begin
                $display("%0t: unexpected bus word, expected none, actual addr %h wr %b",
                         $time, o_bus_address, o_bus_write);
                err_cnt++;
            end else begin
                want_w = bus_q.pop_front();
                check_field("bus_write", 16'(want_w.bus_write), 16'(o_bus_write));
                check_field("bus_address", want_w.bus_address, o_bus_address);
                check_field("write_data", 16'(want_w.write_data), 16'(o_write_data));
                check_field("instr_done", 16'(want_w.instr_done), 16'(o_instr_done));
                check_field("instr_cycles", 16'(want_w.instr_cycles),
                            16'(o_instr_cycles));
                check_field("fault", 16'(want_w.fault), 16'(o_fault));
                check_field("acc_value", 16'(want_w.acc_value), 16'(o_acc_value));
                check_field("flag_bits", 16'(want_w.flag_bits), 16'(o_flag_bits));
                check_field("end_of_run", 16'(want_w.end_of_run), 16'(o_end_of_run));
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    int   word_cnt = 0;
    t_row script [$];

    function automatic void put(logic f, logic [7:0] d);
        t_row row;
        row       = '0;
        row.func  = f;
        row.data  = d;
        script.push_back(row);
    endfunction

    // rows whose single bus word is read requests only, typed in by hand
    function automatic void put_known(logic f, logic [7:0] d, logic [15:0] addr,
                                      logic done, logic [4:0] cyc, logic flt,
                                      logic [7:0] acc, logic [3:0] fl);
        t_row row;
        row                    = '0;
        row.func               = f;
        row.data               = d;
        row.known              = 1'b1;
        row.want.bus_address   = addr;
        row.want.instr_done    = done;
        row.want.instr_cycles  = cyc;
        row.want.fault         = flt;
        row.want.acc_value     = acc;
        row.want.flag_bits     = fl;
        row.want.end_of_run    = 1'b1;
        script.push_back(row);
    endfunction

    // Drive one word and hold it until accepted; called and returning at a
    // rising edge. Prediction runs at the accepting edge.
    task automatic send(logic f, logic [7:0] d, logic known, sm83_pkg::t_result want);
        sm83_pkg::t_result r;
        if (!quiet && (word_cnt % 256) < 160 && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= f;
        i_read_data <= d;
        do @(posedge i_clk); while (o_in_stall);
        word_cnt++;
        exec_word(f, d);
        if (known) begin
            bus_q.push_back(want);
        end else begin
            for (int j = 0; j < step_n; j++) begin
                r            = step_res[j];
                r.end_of_run = (j == step_n - 1);
                bus_q.push_back(r);
            end
        end
    endtask

    task automatic walk_script();
        t_row row;
        while (script.size() != 0) begin
            row = script.pop_front();
            send(row.func, row.data, row.known, row.want);
        end
    endtask

    function automatic logic [7:0] pick_op();
        return GOOD_OPS[$urandom_range(0, 14)];
    endfunction

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_func      <= sm83_pkg::FUNC_START;
        i_read_data <= 8'h00;
        i_out_stall <= 1'b0;
        cpu_reset();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed program from reset state ---
        put(sm83_pkg::FUNC_DATA, 8'hFF);       // read data before any start: no word
        put_known(sm83_pkg::FUNC_START, 8'h00, 16'h0100, 1'b0, 5'd0, 1'b0, 8'h01, 4'hB);
        put_known(sm83_pkg::FUNC_DATA, sm83_pkg::OP_NOP, 16'h0101, 1'b1, 5'd4, 1'b0,
                  8'h01, 4'hB);
        // Z set out of reset: branch skipped without reading the offset
        put_known(sm83_pkg::FUNC_DATA, sm83_pkg::OP_JR_NZ, 16'h0103, 1'b1, 5'd8, 1'b0,
                  8'h01, 4'hB);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_DEC_B);     // 00 -> FF, half borrow
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_JR_NZ);     // taken, most negative offset
        put(sm83_pkg::FUNC_DATA, 8'h80);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_DEC_C);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_LD_A_N);
        put(sm83_pkg::FUNC_DATA, 8'hFF);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_CP_N);
        put(sm83_pkg::FUNC_DATA, 8'h00);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_LDD_HL);    // store then next fetch
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_LDH_ST);    // top of the high page
        put(sm83_pkg::FUNC_DATA, 8'hFF);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_LDH_LD);    // bottom of the high page
        put(sm83_pkg::FUNC_DATA, 8'h00);
        put(sm83_pkg::FUNC_DATA, 8'h00);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_LD_HL);     // HL = 0000, then LDD wraps it
        put(sm83_pkg::FUNC_DATA, 8'h00);
        put(sm83_pkg::FUNC_DATA, 8'h00);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_LDD_HL);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_LD_C_N);
        put(sm83_pkg::FUNC_START, 8'h00);                 // restart with an operand outstanding
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_DI);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_LD_B_N);
        put(sm83_pkg::FUNC_DATA, 8'h7F);
        walk_script();

        // --- random programs: mostly well-formed, some restarts mid-instruction ---
        for (int k = 0; k < RAND_WORDS; k++) begin
            quiet = (k >= RAND_WORDS - CALM_WORDS);
            if (cpu_ph == ST_IDLE || $urandom_range(0, 39) == 0)
                send(sm83_pkg::FUNC_START, 8'($urandom_range(0, 255)), 1'b0, '0);
            else if (cpu_ph == ST_OPCODE)
                send(sm83_pkg::FUNC_DATA, pick_op(), 1'b0, '0);
            else
                send(sm83_pkg::FUNC_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
        end

        // --- closing: jump to a known spot, fault there, stay halted ---
        put(sm83_pkg::FUNC_START, 8'h00);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_XOR_A);
        put(sm83_pkg::FUNC_DATA, sm83_pkg::OP_JP);
        put(sm83_pkg::FUNC_DATA, 8'h34);
        put_known(sm83_pkg::FUNC_DATA, 8'h12, 16'h1234, 1'b1, 5'd16, 1'b0, 8'h00, 4'h8);
        put_known(sm83_pkg::FUNC_DATA, BAD_OPCODE, 16'h1234, 1'b0, 5'd0, 1'b1,
                  8'h00, 4'h8);
        put_known(sm83_pkg::FUNC_START, 8'hFF, 16'h1234, 1'b0, 5'd0, 1'b1, 8'h00, 4'h8);
        put_known(sm83_pkg::FUNC_DATA, 8'h00, 16'h1234, 1'b0, 5'd0, 1'b1, 8'h00, 4'h8);
        walk_script();
        i_in_valid <= 1'b0;

        while (bus_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);   // catch stray words after the last one

        if (err_cnt == 0)
            $display("sm83_cpu_subset_core test passed");
        else
            $display("sm83_cpu_subset_core test failed");
        $finish;
    end

endmodule

FILE: sm83_cpu_subset_core.f
rtl/sm83_pkg.sv
rtl/sm83_exec.sv
rtl/sm83_outq.sv
rtl/sm83_cpu_subset_core.sv
dv/tb.sv
